@@ sv/rsr_pkg.sv @@
// Package for the polyphase resampler: request and result payload types,
// request kinds and configuration register indexes. No dependencies.
package rsr_pkg;

  typedef struct packed {
    logic [2:0]         kind;
    logic [14:0]        coef_index;
    logic signed [15:0] coef_value;
    logic [15:0]        sample_address;
    logic signed [15:0] sample_left;
    logic signed [15:0] sample_right;
    logic [23:0]        new_position;
  } rsr_in_t;

  typedef struct packed {
    logic signed [15:0] out_left;
    logic signed [15:0] out_right;
    logic [23:0]        position;
  } rsr_out_t;

  localparam logic [2:0] KIND_COEF   = 3'd0;
  localparam logic [2:0] KIND_SAMPLE = 3'd1;
  localparam logic [2:0] KIND_TICK   = 3'd2;
  localparam logic [2:0] KIND_SEEK   = 3'd3;
  localparam logic [2:0] KIND_PLAY   = 3'd4;
  localparam logic [2:0] KIND_STOP   = 3'd5;

  localparam logic [2:0] REG_SOURCE_RATE = 3'd0;
  localparam logic [2:0] REG_OUTPUT_RATE = 3'd1;
  localparam logic [2:0] REG_GAIN        = 3'd2;
  localparam logic [2:0] REG_SOURCE_CH   = 3'd3;
  localparam logic [2:0] REG_OUTPUT_CH   = 3'd4;

  localparam int RATE_WIDTH = 18;
  localparam int GAIN_WIDTH = 17;
  localparam logic [16:0] UNITY_GAIN = 17'd32768;
  localparam int OUT_SHIFT = 29;

endpackage

@@ sv/rsr_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rsr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ sv/rsr_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by the phase lookup
// and the position advance. Depends on rsr_pkg.
module rsr_div import rsr_pkg::*; #(
  parameter int DW = 31
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DW-1:0]         dividend,
  input  logic [RATE_WIDTH-1:0] divisor,
  output logic                  done,
  output logic [DW-1:0]         quot,
  output logic [RATE_WIDTH-1:0] rem
);
  localparam int CNTW = $clog2(DW + 1);

  logic [CNTW-1:0]       cnt;
  logic                  busy;
  logic [RATE_WIDTH-1:0] dvs;
  logic [RATE_WIDTH:0]   trial;
  logic                  fits;

  assign trial = {rem, quot[DW-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      quot <= {quot[DW-2:0], fits};
      rem  <= fits ? RATE_WIDTH'(trial - {1'b0, dvs}) : trial[RATE_WIDTH-1:0];
    end
  end
endmodule

@@ sv/rsr_mac.sv @@
// Shared signed multiplier with registered product, used for every tap and
// for the gain step. Depends on rsr_pkg.
module rsr_mac import rsr_pkg::*; #(
  parameter int AW = 35
) (
  input  logic                         clk,
  input  logic signed [AW-1:0]         a,
  input  logic signed [GAIN_WIDTH-1:0] b,
  output logic signed [AW+GAIN_WIDTH-1:0] p
);
  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule

@@ sv/polyphase_sinc_resampler.sv @@
// Polyphase 8-tap windowed-sinc resampler. Requests load coefficients, write
// stereo samples, seek, play, stop or ask for one output frame. Requests other
// than a tick are taken one per cycle; a stopped tick goes straight to the
// output step. A playing tick runs the shared divider twice (phase lookup and
// advance), plus the read, multiply and accumulate steps for each of 16 taps on
// the shared multiplier, the gain and gain-write steps per channel, and the
// output step before it returns to idle. A tick waits in the output step while
// the previous frame is still unaccepted. After reset the sample stores are
// cleared one entry a cycle, all STORE_DEPTH entries, while no request is taken;
// configuration writes are accepted throughout.
module polyphase_sinc_resampler import rsr_pkg::*; #(
  parameter int PHASES       = 8192,
  parameter int STORE_DEPTH  = 65536,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  rsr_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output rsr_out_t    out_data
);
  localparam int PB  = $clog2(PHASES);
  localparam int CW  = PB + 2;
  localparam int SAW = $clog2(STORE_DEPTH);
  localparam int DW  = RATE_WIDTH + PB;
  localparam int AW  = SAMPLE_WIDTH + 19;
  localparam int PW  = AW + GAIN_WIDTH;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DIV1  = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_ACC   = 4'd5;
  localparam logic [3:0] S_GAIN  = 4'd6;
  localparam logic [3:0] S_GAINW = 4'd7;
  localparam logic [3:0] S_DIV2  = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  // configuration
  logic [RATE_WIDTH-1:0] source_rate, output_rate;
  logic [15:0]           gain;
  logic [1:0]            source_channels, output_channels;
  logic                  cfg_we;
  logic [2:0]            cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_rate     <= RATE_WIDTH'(44100);
      output_rate     <= RATE_WIDTH'(44100);
      gain            <= 16'd32768;
      source_channels <= 2'd2;
      output_channels <= 2'd2;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SOURCE_RATE: source_rate <= pwdata[RATE_WIDTH-1:0];
        REG_OUTPUT_RATE: begin
          if (pwdata[RATE_WIDTH-1:0] != '0) output_rate <= pwdata[RATE_WIDTH-1:0];
        end
        REG_GAIN:        gain <= pwdata[15:0];
        REG_SOURCE_CH:   source_channels <= pwdata[1:0];
        REG_OUTPUT_CH:   output_channels <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SOURCE_RATE: prdata = 32'(source_rate);
      REG_OUTPUT_RATE: prdata = 32'(output_rate);
      REG_GAIN:        prdata = 32'(gain);
      REG_SOURCE_CH:   prdata = 32'(source_channels);
      REG_OUTPUT_CH:   prdata = 32'(output_channels);
      default:         prdata = '0;
    endcase
  end

  // sequencer state
  logic [3:0]            state;
  logic [SAW-1:0]        clr_cnt;
  logic                  running;
  logic [23:0]           play_pos;
  logic [RATE_WIDTH-1:0] phase_acc;
  logic [PB-1:0]         phase_n;
  logic [2:0]            tap;
  logic                  ch;
  logic                  tap_ok;
  logic signed [AW-1:0]  acc;
  logic signed [15:0]    res_l, res_r;
  logic                  accept;

  assign in_ready = state == S_IDLE;
  assign accept   = in_valid && in_ready;

  // store read address for the current tap, position -3..+4
  logic [25:0]          tpos;
  logic                 tpos_ok;
  logic [SAW-1:0]       s_raddr;
  logic [CW-1:0]        c_raddr;
  assign tpos    = {2'b00, play_pos} + 26'(tap);
  assign tpos_ok = (tpos >= 26'd3) && ((tpos - 26'd3) < 26'(STORE_DEPTH));
  assign s_raddr = SAW'(tpos - 26'd3);
  assign c_raddr = tap[2] ? {~phase_n, tap[1:0]} : {phase_n, ~tap[1:0]};

  // memories
  logic [SAMPLE_WIDTH-1:0] l_rdata, r_rdata, l_wdata, r_wdata;
  logic [SAW-1:0]          s_waddr;
  logic                    s_we, s_in_range;
  logic [15:0]             c_rdata;

  assign s_in_range = 25'(in_data.sample_address) < 25'(STORE_DEPTH);
  assign s_we    = (state == S_CLEAR) ||
                   (accept && in_data.kind == KIND_SAMPLE && s_in_range);
  assign s_waddr = (state == S_CLEAR) ? clr_cnt : SAW'(in_data.sample_address);
  assign l_wdata = (state == S_CLEAR) ? '0 : SAMPLE_WIDTH'($signed(in_data.sample_left));
  assign r_wdata = (state == S_CLEAR) ? '0 : SAMPLE_WIDTH'($signed(in_data.sample_right));

  rsr_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(STORE_DEPTH)) u_left (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(l_wdata),
    .raddr(s_raddr), .rdata(l_rdata)
  );
  rsr_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(STORE_DEPTH)) u_right (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(r_wdata),
    .raddr(s_raddr), .rdata(r_rdata)
  );
  rsr_ram #(.WIDTH(16), .DEPTH(PHASES * 4)) u_coef (
    .clk(clk), .we(accept && in_data.kind == KIND_COEF),
    .waddr(CW'(in_data.coef_index)), .wdata(in_data.coef_value),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  // shared divider
  logic          div_start, div_done;
  logic [DW-1:0] div_dividend, div_quot;
  logic [RATE_WIDTH-1:0] div_rem;

  rsr_div #(.DW(DW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dividend),
    .divisor(output_rate), .done(div_done), .quot(div_quot), .rem(div_rem)
  );

  // shared multiplier
  logic signed [AW-1:0]         mac_a;
  logic signed [GAIN_WIDTH-1:0] mac_b;
  logic signed [PW-1:0]         mac_p;
  logic [SAMPLE_WIDTH-1:0]      samp;
  logic [GAIN_WIDTH-1:0]        geff;

  assign samp = (ch && source_channels != 2'd1) ? r_rdata : l_rdata;
  assign geff = ({1'b0, gain} > UNITY_GAIN) ? UNITY_GAIN : {1'b0, gain};

  always_comb begin
    if (state == S_GAIN) begin
      mac_a = acc;
      mac_b = $signed(geff);
    end else begin
      mac_a = tap_ok ? AW'($signed(samp)) : '0;
      mac_b = GAIN_WIDTH'($signed(c_rdata));
    end
  end

  rsr_mac #(.AW(AW)) u_mac (.clk(clk), .a(mac_a), .b(mac_b), .p(mac_p));

  // round half up, then saturate
  logic signed [PW-1:0] rsum;
  logic signed [31:0]   rval;
  logic signed [15:0]   sat;
  assign rsum = mac_p + (PW'(1) <<< (OUT_SHIFT - 1));
  assign rval = 32'($signed(rsum[PW-1:OUT_SHIFT]));
  always_comb begin
    if (rval > 32'sd32767)       sat = 16'sd32767;
    else if (rval < -32'sd32768) sat = -16'sd32768;
    else                         sat = rval[15:0];
  end

  assign div_start    = (accept && in_data.kind == KIND_TICK && running) ||
                        (state == S_GAINW && ch);
  assign div_dividend = (state == S_IDLE) ? {phase_acc, PB'(0)}
                      : DW'({1'b0, phase_acc} + {1'b0, source_rate});

  logic out_free;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      running   <= 1'b0;
      play_pos  <= '0;
      phase_acc <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_OUT && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == SAW'(STORE_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            case (in_data.kind)
              KIND_SEEK: begin
                play_pos  <= in_data.new_position;
                phase_acc <= '0;
              end
              KIND_PLAY: running <= 1'b1;
              KIND_STOP: running <= 1'b0;
              KIND_TICK: begin
                res_l <= '0;
                res_r <= '0;
                state <= running ? S_DIV1 : S_OUT;
              end
              default: ;
            endcase
          end
        end
        S_DIV1: begin
          if (div_done) begin
            phase_n <= div_quot[PB-1:0];
            tap     <= '0;
            ch      <= 1'b0;
            acc     <= '0;
            state   <= S_RD;
          end
        end
        S_RD: begin
          tap_ok <= tpos_ok;
          state  <= S_MUL;
        end
        S_MUL: state <= S_ACC;
        S_ACC: begin
          acc <= acc + AW'(mac_p);
          tap <= tap + 1'b1;
          state <= (tap == 3'd7) ? S_GAIN : S_RD;
        end
        S_GAIN: state <= S_GAINW;
        S_GAINW: begin
          if (!ch) begin
            res_l <= sat;
            ch    <= 1'b1;
            acc   <= '0;
            state <= S_RD;
          end else begin
            res_r <= sat;
            state <= S_DIV2;
          end
        end
        S_DIV2: begin
          if (div_done) begin
            play_pos  <= play_pos + div_quot[23:0];
            phase_acc <= div_rem;
            // mask by channel settings
            if (source_channels == 2'd0 || output_channels == 2'd0) res_l <= '0;
            if (source_channels == 2'd0 || output_channels[1] == 1'b0) res_r <= '0;
            else if (source_channels == 2'd1) res_r <= res_l;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      out_data.out_left  <= res_l;
      out_data.out_right <= res_r;
      out_data.position  <= play_pos;
    end
  end
endmodule

@@ sv/rsr_checker.sv @@
// Port-level checks for the resampler, bound to the top level.
// Depends on rsr_pkg and polyphase_sinc_resampler.
module rsr_checker import rsr_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     pready,
  input logic     in_valid,
  input logic     in_ready,
  input rsr_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input rsr_out_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.kind == KIND_TICK |=> !in_ready)
    else $error("request taken while a tick is in work");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.kind != KIND_TICK && !out_valid |=> !out_valid)
    else $error("result without a tick");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");
endmodule

bind polyphase_sinc_resampler rsr_checker u_rsr_checker (
  .clk(clk), .rst(rst), .pready(pready), .in_valid(in_valid), .in_ready(in_ready),
  .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
